// File: design/qte_pkg.sv
// Types, character codes and helpers shared by the quoted token extractor.
// No dependencies; imported by every other file of the block.
package qte_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int DEPTH_BITS_DEF = 8;
    localparam int CONSUMED_BITS  = 16;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;

    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_RUN  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_marker;
    } in_word_t;

    typedef struct packed {
        logic                     kind;
        logic [7:0]               char_out;
        logic [CONSUMED_BITS-1:0] consumed;
        logic                     only_white;
        logic                     unterminated;
        logic                     last_of_run;
    } out_word_t;

    // results of one item, in delivery order
    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } res_pair_t;

    function automatic logic is_space_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic out_word_t char_word(input logic [7:0] c);
        out_word_t w;
        w              = '0;
        w.kind         = KIND_CHAR;
        w.char_out     = c;
        return w;
    endfunction

endpackage

// File: design/quoted_token_extractor_unit.sv
// Quoted token extractor: input register, parse logic, two-word result buffer.
// An accepted word is held in the input register until the buffer has room; its results are then
// registered into the buffer slots. Throughput: one word per cycle while result_stall is low; a
// word with two results holds the input while the single result port drains the two-entry buffer.
// Reset (rst_n low, asynchronous): parse state to skipping whitespace, buffers empty.
// Depends on qte_pkg and qte_parse.
module quoted_token_extractor_unit #(
    parameter int COUNT_BITS = qte_pkg::COUNT_BITS_DEF,
    parameter int DEPTH_BITS = qte_pkg::DEPTH_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  qte_pkg::in_word_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output qte_pkg::out_word_t result
);
    import qte_pkg::*;

    logic       in_valid_reg, in_valid_next;
    in_word_t   in_data_reg;
    out_word_t  slot0_reg, slot0_next;
    out_word_t  slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       room, advance, pop, accept;
    res_pair_t  res;

    qte_parse #(
        .COUNT_BITS (COUNT_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .word    (in_data_reg),
        .res     (res)
    );

    assign result_valid = (cnt_reg != 2'd0);
    assign result       = slot0_reg;
    assign pop          = result_valid && !result_stall;
    // need both slots free after this cycle's pop
    assign room         = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && !result_stall);
    assign advance      = in_valid_reg && room;
    assign item_stall   = in_valid_reg && !advance;
    assign accept       = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (advance)
        begin
            slot0_next = res.first;
            slot1_next = res.second;
            cnt_next   = res.count;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_data_reg <= item;
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// File: design/qte_parse.sv
// Token parse state and the per-word decision logic of the extractor.
// Depends on qte_pkg. State advances only on an advance strobe from the top level.
module qte_parse #(
    parameter int COUNT_BITS = qte_pkg::COUNT_BITS_DEF,
    parameter int DEPTH_BITS = qte_pkg::DEPTH_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  qte_pkg::in_word_t   word,
    output qte_pkg::res_pair_t  res
);
    import qte_pkg::*;

    localparam int CW = (COUNT_BITS > CONSUMED_BITS) ? COUNT_BITS : CONSUMED_BITS;
    localparam logic signed [DEPTH_BITS-1:0] DMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0]        CMAX = {COUNT_BITS{1'b1}};

    phase_t                        phase_reg, phase_next;
    logic                          quoted_reg, quoted_next;
    logic                          tag_reg, tag_next;
    logic                          prev_bs_reg, prev_bs_next;
    logic                          inside_reg, inside_next;
    logic                          held_reg, held_next;
    logic signed [DEPTH_BITS-1:0]  depth_reg, depth_next;
    logic [COUNT_BITS-1:0]         pos_reg, pos_next;

    logic [COUNT_BITS-1:0]         pos_inc;
    logic [CW-1:0]                 pos_wide, pos_inc_wide;
    logic [CONSUMED_BITS-1:0]      cons_now, cons_inc;

    assign pos_inc      = (pos_reg == CMAX) ? pos_reg : pos_reg + 1'b1;
    assign pos_wide     = CW'(pos_reg);
    assign pos_inc_wide = CW'(pos_inc);
    assign cons_now     = (pos_wide > CW'({CONSUMED_BITS{1'b1}})) ? {CONSUMED_BITS{1'b1}}
                                                                   : pos_wide[CONSUMED_BITS-1:0];
    assign cons_inc     = (pos_inc_wide > CW'({CONSUMED_BITS{1'b1}})) ? {CONSUMED_BITS{1'b1}}
                                                                       : pos_inc_wide[CONSUMED_BITS-1:0];

    always_comb
    begin
        logic [7:0]                   c;
        logic                         white;
        logic                         eff_tag;
        logic                         term;
        logic                         held_emit;
        logic                         main_valid;
        out_word_t                    main_w;
        logic signed [DEPTH_BITS-1:0] d1;

        c          = word.byte_in;
        white      = is_space_char(c);
        eff_tag    = tag_reg;
        term       = 1'b0;
        held_emit  = 1'b0;
        main_valid = 1'b0;
        main_w     = '0;
        d1         = depth_reg;

        phase_next   = phase_reg;
        quoted_next  = quoted_reg;
        tag_next     = tag_reg;
        prev_bs_next = prev_bs_reg;
        inside_next  = inside_reg;
        held_next    = held_reg;
        depth_next   = depth_reg;
        pos_next     = pos_reg;

        if (word.end_marker)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    main_valid        = 1'b1;
                    main_w.kind       = KIND_REPORT;
                    main_w.consumed   = cons_now;
                    main_w.only_white = 1'b1;
                end
                PH_RUN:
                begin
                    held_emit           = held_reg;
                    main_valid          = 1'b1;
                    main_w.kind         = KIND_REPORT;
                    main_w.consumed     = cons_now;
                    main_w.unterminated = quoted_reg;
                end
                default: ;
            endcase
            phase_next   = PH_SKIP;
            quoted_next  = 1'b0;
            tag_next     = 1'b0;
            prev_bs_next = 1'b0;
            inside_next  = 1'b0;
            held_next    = 1'b0;
            depth_next   = '0;
            pos_next     = '0;
        end
        else if (phase_reg == PH_SKIP && white)
        begin
            pos_next = pos_inc;
        end
        else if (phase_reg == PH_SKIP && c == CH_QUOTE)
        begin
            phase_next  = PH_RUN;
            quoted_next = 1'b1;
            pos_next    = pos_inc;
        end
        else if (phase_reg != PH_DONE)
        begin
            if (phase_reg == PH_SKIP)
            begin
                eff_tag    = (c == CH_DOLLAR);
                phase_next = PH_RUN;
                tag_next   = eff_tag;
            end
            // held backslash: dropped before whitespace or a quote
            if (held_reg)
            begin
                held_next = 1'b0;
                held_emit = !(white || c == CH_QUOTE);
            end

            if (c == CH_BACKSLASH && prev_bs_reg)
            begin
                prev_bs_next = 1'b0;
                main_valid   = 1'b1;
                main_w       = char_word(c);
                pos_next     = pos_inc;
            end
            else
            begin
                if (!prev_bs_reg && !inside_reg)
                begin
                    if (c == CH_RBRACE && depth_reg > DMIN)
                        d1 = depth_reg - 1'b1;
                    else if (c == CH_LBRACE && depth_reg < DMAX)
                        d1 = depth_reg + 1'b1;
                end
                depth_next = d1;

                if (!prev_bs_reg)
                    term = quoted_reg ? (c == CH_QUOTE)
                                      : (white && (!eff_tag || d1 == '0));

                if (term)
                begin
                    main_valid      = 1'b1;
                    main_w.kind     = KIND_REPORT;
                    main_w.consumed = quoted_reg ? cons_inc : cons_now;
                    phase_next      = PH_DONE;
                end
                else
                begin
                    pos_next = pos_inc;
                    if (c == CH_QUOTE)
                    begin
                        inside_next = !inside_reg;
                        main_valid  = 1'b1;
                        main_w      = char_word(c);
                    end
                    else if (!quoted_reg && c == CH_BACKSLASH && !prev_bs_reg)
                    begin
                        held_next    = 1'b1;
                        prev_bs_next = 1'b1;
                    end
                    else
                    begin
                        main_valid   = 1'b1;
                        main_w       = char_word(c);
                        prev_bs_next = (c == CH_BACKSLASH);
                    end
                end
            end
        end

        main_w.last_of_run = 1'b1;
        res.count  = {1'b0, held_emit} + {1'b0, main_valid};
        res.second = main_w;
        if (held_emit)
        begin
            res.first             = char_word(CH_BACKSLASH);
            res.first.last_of_run = !main_valid;
        end
        else
        begin
            res.first = main_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SKIP;
            quoted_reg  <= 1'b0;
            tag_reg     <= 1'b0;
            prev_bs_reg <= 1'b0;
            inside_reg  <= 1'b0;
            held_reg    <= 1'b0;
            depth_reg   <= '0;
            pos_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            quoted_reg  <= quoted_next;
            tag_reg     <= tag_next;
            prev_bs_reg <= prev_bs_next;
            inside_reg  <= inside_next;
            held_reg    <= held_next;
            depth_reg   <= depth_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

// File: design/qte_checker.sv
// Port-level checks for quoted_token_extractor_unit, bound to the top level.
// Depends on qte_pkg.
module qte_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input qte_pkg::in_word_t  item,
    input logic               result_valid,
    input logic               result_stall,
    input qte_pkg::out_word_t result
);
    import qte_pkg::*;

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("input word changed while stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_CHAR |->
            result.consumed == '0 && !result.only_white && !result.unterminated)
        else $error("character word carries report fields");

    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_REPORT |->
            result.char_out == 8'h00 && result.last_of_run)
        else $error("report word not last or has a character");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.only_white |-> !result.unterminated)
        else $error("whitespace-only report marked unterminated");

endmodule

bind quoted_token_extractor_unit qte_checker u_qte_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
